[sv/chm_pkg.sv]
// ----------------------------------------------------------------------------
// chm_pkg
// Shared types and constants of the chained hash map.
// ----------------------------------------------------------------------------
package chm_pkg;
   localparam int ENTRY_SLOTS = 256;
   localparam int BIN_COUNT   = 512;
   localparam int SLOT_W      = $clog2(ENTRY_SLOTS);
   localparam int PTR_W       = SLOT_W + 1;
   localparam int BIN_W       = $clog2(BIN_COUNT);
   localparam int CNT_W       = PTR_W;
   localparam int STEP_W      = SLOT_W + 1;

   localparam logic [1:0] REQ_SET = 2'd0;
   localparam logic [1:0] REQ_GET = 2'd1;
   localparam logic [1:0] REQ_DEL = 2'd2;
   localparam logic [1:0] REQ_BAD = 2'd3;  // unknown request, changes nothing

   // Datapath commands, one per controller step.
   localparam logic [3:0] CMD_NONE    = 4'd0;
   localparam logic [3:0] CMD_LOAD    = 4'd1;  // capture request, read bin head
   localparam logic [3:0] CMD_HEAD    = 4'd2;  // take bin head as current
   localparam logic [3:0] CMD_RDSLOT  = 4'd3;  // read key/value/link of current
   localparam logic [3:0] CMD_ADVANCE = 4'd4;  // move to next slot in chain
   localparam logic [3:0] CMD_UPDATE  = 4'd5;  // set hit: write value
   localparam logic [3:0] CMD_FRLINK  = 4'd6;  // read link of free head
   localparam logic [3:0] CMD_INSERT  = 4'd7;  // link fresh slot at bin head
   localparam logic [3:0] CMD_UNLINK  = 4'd8;  // delete hit: unlink, count down
   localparam logic [3:0] CMD_RESULT  = 4'd9;  // build result, free a deleted slot
   localparam logic [3:0] CMD_CLEAR   = 4'd10; // clearing pass step

   typedef struct packed {
      logic [3:0] cmd;
      logic       hit;
      logic       full;
   } cmd_type;

   typedef struct packed {
      logic [1:0] req;
      logic       cur_null;
      logic       key_match;
      logic       free_null;
      logic       clear_done;
      logic       step_limit;
   } status_type;
endpackage

[sv/chained_hash_map.sv]
// ----------------------------------------------------------------------------
// chained_hash_map
// Hash table with separate chaining over a fixed pool of entry slots.
// ----------------------------------------------------------------------------
// Sequence: the request is captured and its bin head read, the head is taken as current,
// then each chain entry passed is read and compared; an insert or a delete has a step of its own.
// Throughput: one transaction at a time; the next is taken no earlier than the cycle in which
// the response is accepted.
// Reset: synchronous; afterwards a clearing pass over every bin head empties the bin heads
// and links every slot into the free list, taking no request.
module chained_hash_map (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [1:0]    req_tuser,   // req_type
   input  logic [127:0]  req_tdata,   // key [63:0], value [127:64]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [79:0]   rsp_tdata    // hit, read_value, table_full, stored_count, zero pad
);
   chm_pkg::cmd_type    cmd;
   chm_pkg::status_type status;
   logic        hit, full;
   logic [63:0] read_value;
   logic [chm_pkg::CNT_W-1:0] stored_count;

   // The controller sequences every transaction; the datapath holds all storage.
   chm_control u_ctl (
      .clock(clock), .reset(reset), .status(status), .cmd(cmd),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready)
   );

   chm_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .req_type(req_tuser), .req_key(req_tdata[63:0]), .req_value(req_tdata[127:64]),
      .res_hit(hit), .res_read_value(read_value), .res_table_full(full),
      .res_stored_count(stored_count)
   );

   // Result fields packed from the lowest bit up, zero filled to whole bytes.
   assign rsp_tdata = {5'd0, stored_count, full, read_value, hit};
endmodule

[sv/chm_datapath.sv]
// ----------------------------------------------------------------------------
// chm_datapath
// Memories, pointers and counters of the hash map, driven step by step.
// ----------------------------------------------------------------------------
module chm_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  chm_pkg::cmd_type      cmd,
   output chm_pkg::status_type   status,
   input  logic [1:0]            req_type,
   input  logic [63:0]           req_key,
   input  logic [63:0]           req_value,
   output logic                  res_hit,
   output logic [63:0]           res_read_value,
   output logic                  res_table_full,
   output logic [chm_pkg::CNT_W-1:0] res_stored_count
);
   localparam logic [chm_pkg::PTR_W-1:0] NULLP = chm_pkg::PTR_W'(chm_pkg::ENTRY_SLOTS);

   logic [chm_pkg::PTR_W-1:0] bin_mem [chm_pkg::BIN_COUNT];
   logic [chm_pkg::PTR_W-1:0] link_mem [chm_pkg::ENTRY_SLOTS];
   logic [63:0] key_mem [chm_pkg::ENTRY_SLOTS];
   logic [63:0] val_mem [chm_pkg::ENTRY_SLOTS];

   logic [1:0]  req_ff;
   logic [63:0] key_ff, value_ff;
   logic [chm_pkg::BIN_W-1:0] bin_ff;
   logic [chm_pkg::PTR_W-1:0] head_rd_ff, link_rd_ff, cur_ff, prev_ff;
   logic [63:0] key_rd_ff, val_rd_ff;
   logic [chm_pkg::PTR_W-1:0] free_ff, total_ff;
   logic [chm_pkg::BIN_W:0]   clr_ff;
   logic [chm_pkg::STEP_W-1:0] steps_ff;
   logic [31:0] folded;
   logic [chm_pkg::SLOT_W-1:0] cur_idx, prev_idx, free_idx;

   assign folded   = req_key[31:0] ^ req_key[63:32];
   assign cur_idx  = cur_ff[chm_pkg::SLOT_W-1:0];
   assign prev_idx = prev_ff[chm_pkg::SLOT_W-1:0];
   assign free_idx = free_ff[chm_pkg::SLOT_W-1:0];

   assign status.req        = req_ff;
   assign status.cur_null   = cur_ff[chm_pkg::PTR_W-1];
   assign status.key_match  = (key_rd_ff == key_ff);
   assign status.free_null  = free_ff[chm_pkg::PTR_W-1];
   assign status.clear_done = clr_ff[chm_pkg::BIN_W];
   assign status.step_limit = steps_ff[chm_pkg::STEP_W-1];

   // Bin head memory: cleared by a pass after reset.
   always_ff @(posedge clock) begin
      if (cmd.cmd == chm_pkg::CMD_CLEAR) begin
         bin_mem[clr_ff[chm_pkg::BIN_W-1:0]] <= NULLP;
      end else if (cmd.cmd == chm_pkg::CMD_INSERT) begin
         bin_mem[bin_ff] <= free_ff;
      end else if (cmd.cmd == chm_pkg::CMD_UNLINK && prev_ff[chm_pkg::PTR_W-1]) begin
         bin_mem[bin_ff] <= link_rd_ff;
      end
      if (cmd.cmd == chm_pkg::CMD_LOAD) begin
         head_rd_ff <= bin_mem[folded[chm_pkg::BIN_W-1:0]];
      end
   end

   // Link memory: single write port, registered read.
   always_ff @(posedge clock) begin
      if (cmd.cmd == chm_pkg::CMD_CLEAR) begin
         link_mem[clr_ff[chm_pkg::SLOT_W-1:0]] <=
            PTR_W_next(clr_ff[chm_pkg::SLOT_W-1:0]);
      end else if (cmd.cmd == chm_pkg::CMD_INSERT) begin
         link_mem[free_idx] <= head_rd_ff;
      end else if (cmd.cmd == chm_pkg::CMD_UNLINK) begin
         if (!prev_ff[chm_pkg::PTR_W-1]) link_mem[prev_idx] <= link_rd_ff;
      end else if (cmd.cmd == chm_pkg::CMD_RESULT && req_ff == chm_pkg::REQ_DEL
                   && cmd.hit) begin
         link_mem[cur_idx] <= free_ff;
      end
      if (cmd.cmd == chm_pkg::CMD_RDSLOT) begin
         link_rd_ff <= link_mem[cur_idx];
      end else if (cmd.cmd == chm_pkg::CMD_FRLINK) begin
         link_rd_ff <= link_mem[free_idx];
      end
   end

   function automatic logic [chm_pkg::PTR_W-1:0] PTR_W_next(
      input logic [chm_pkg::SLOT_W-1:0] i);
      PTR_W_next = {1'b0, i} + chm_pkg::PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.cmd == chm_pkg::CMD_INSERT) begin
         key_mem[free_idx] <= key_ff;
      end
      if (cmd.cmd == chm_pkg::CMD_RDSLOT) begin
         key_rd_ff <= key_mem[cur_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cmd == chm_pkg::CMD_INSERT) begin
         val_mem[free_idx] <= value_ff;
      end else if (cmd.cmd == chm_pkg::CMD_UPDATE) begin
         val_mem[cur_idx] <= value_ff;
      end
      if (cmd.cmd == chm_pkg::CMD_RDSLOT) begin
         val_rd_ff <= val_mem[cur_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cmd == chm_pkg::CMD_LOAD) begin
         req_ff   <= req_type;
         key_ff   <= req_key;
         value_ff <= req_value;
         bin_ff   <= folded[chm_pkg::BIN_W-1:0];
      end
      case (cmd.cmd)
         chm_pkg::CMD_HEAD: begin
            cur_ff   <= head_rd_ff;
            prev_ff  <= NULLP;
            steps_ff <= '0;
         end
         chm_pkg::CMD_ADVANCE: begin
            prev_ff  <= cur_ff;
            cur_ff   <= link_rd_ff;
            steps_ff <= steps_ff + chm_pkg::STEP_W'(1);
         end
         chm_pkg::CMD_RESULT: begin
            res_hit          <= cmd.hit;
            res_table_full   <= cmd.full;
            res_read_value   <= (cmd.hit && req_ff == chm_pkg::REQ_GET) ? val_rd_ff : '0;
            res_stored_count <= total_ff;
         end
         default: begin
         end
      endcase
   end

   // The entry count moves before the result step, so the result reports
   // the count after the transaction.
   always_ff @(posedge clock) begin
      if (reset) begin
         free_ff  <= '0;
         total_ff <= '0;
         clr_ff   <= '0;
      end else begin
         if (cmd.cmd == chm_pkg::CMD_CLEAR) begin
            clr_ff <= clr_ff + (chm_pkg::BIN_W + 1)'(1);
         end
         if (cmd.cmd == chm_pkg::CMD_INSERT) begin
            free_ff  <= link_rd_ff;
            total_ff <= total_ff + chm_pkg::PTR_W'(1);
         end else if (cmd.cmd == chm_pkg::CMD_UNLINK) begin
            if (total_ff != '0) total_ff <= total_ff - chm_pkg::PTR_W'(1);
         end else if (cmd.cmd == chm_pkg::CMD_RESULT && req_ff == chm_pkg::REQ_DEL
                      && cmd.hit) begin
            free_ff <= cur_ff;
         end
      end
   end
endmodule

[sv/chm_control.sv]
// ----------------------------------------------------------------------------
// chm_control
// Sequencer of the hash map: clearing pass, chain walk, update, result.
// ----------------------------------------------------------------------------
module chm_control (
   input  logic                clock,
   input  logic                reset,
   input  chm_pkg::status_type status,
   output chm_pkg::cmd_type    cmd,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready
);
   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_HEAD  = 4'd2;
   localparam logic [3:0] S_CHECK = 4'd3;
   localparam logic [3:0] S_MATCH = 4'd6;
   localparam logic [3:0] S_INS   = 4'd8;
   localparam logic [3:0] S_DEL   = 4'd9;
   localparam logic [3:0] S_RES   = 4'd10;

   logic [3:0] state_ff, state_in;
   logic hit_ff, hit_in, full_ff, full_in, vld_ff, vld_in;

   assign rsp_tvalid = vld_ff;
   assign req_tready = (state_ff == S_IDLE) && (!vld_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      hit_in   = hit_ff;
      full_in  = full_ff;
      vld_in   = vld_ff && !rsp_tready;
      cmd.cmd  = chm_pkg::CMD_NONE;
      cmd.hit  = hit_ff;
      cmd.full = full_ff;
      case (state_ff)
         S_CLEAR: begin
            if (status.clear_done) state_in = S_IDLE;
            else cmd.cmd = chm_pkg::CMD_CLEAR;
         end
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.cmd  = chm_pkg::CMD_LOAD;
               hit_in   = 1'b0;
               full_in  = 1'b0;
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            cmd.cmd  = chm_pkg::CMD_HEAD;
            state_in = (status.req == chm_pkg::REQ_BAD) ? S_RES : S_CHECK;
         end
         S_CHECK: begin
            if (status.cur_null || status.step_limit) begin
               if (status.req == chm_pkg::REQ_SET && !status.free_null) begin
                  cmd.cmd = chm_pkg::CMD_FRLINK;
                  state_in = S_INS;
               end else begin
                  full_in  = (status.req == chm_pkg::REQ_SET);
                  state_in = S_RES;
               end
            end else begin
               cmd.cmd  = chm_pkg::CMD_RDSLOT;
               state_in = S_MATCH;
            end
         end
         S_MATCH: begin
            if (status.key_match) begin
               hit_in = 1'b1;
               if (status.req == chm_pkg::REQ_SET) begin
                  cmd.cmd = chm_pkg::CMD_UPDATE;
                  state_in = S_RES;
               end else if (status.req == chm_pkg::REQ_DEL) begin
                  state_in = S_DEL;
               end else begin
                  state_in = S_RES;
               end
            end else begin
               cmd.cmd  = chm_pkg::CMD_ADVANCE;
               state_in = S_CHECK;
            end
         end
         S_INS: begin
            cmd.cmd  = chm_pkg::CMD_INSERT;
            state_in = S_RES;
         end
         S_DEL: begin
            cmd.cmd  = chm_pkg::CMD_UNLINK;
            state_in = S_RES;
         end
         S_RES: begin
            if (!vld_ff || rsp_tready) begin
               cmd.cmd  = chm_pkg::CMD_RESULT;
               vld_in   = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         hit_ff   <= 1'b0;
         full_ff  <= 1'b0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         hit_ff   <= hit_in;
         full_ff  <= full_in;
         vld_ff   <= vld_in;
      end
   end
endmodule

[tb/chained_hash_map_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chained_hash_map_checker
// Watches both channels of the hash map, keeps its own copy of the table and
// compares every response with the predicted one, in order.
// ----------------------------------------------------------------------------
module chained_hash_map_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [1:0]   req_tuser,
   input  logic [127:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [79:0]  rsp_tdata,
   output int           failures,
   output int           pending
);
   typedef struct {
      logic        hit;
      logic [63:0] read_value;
      logic        table_full;
      logic [8:0]  stored_count;
   } lookup_result_type;

   int          bin_first [chm_pkg::BIN_COUNT];
   int          next_slot [chm_pkg::ENTRY_SLOTS];
   logic [63:0] held_key  [chm_pkg::ENTRY_SLOTS];
   logic [63:0] held_val  [chm_pkg::ENTRY_SLOTS];
   int          free_first;
   int          entries;

   lookup_result_type result_queue[$];

   assign pending = result_queue.size();

   task automatic clear_table();
      for (int i = 0; i < chm_pkg::BIN_COUNT; i++) bin_first[i] = chm_pkg::ENTRY_SLOTS;
      for (int i = 0; i < chm_pkg::ENTRY_SLOTS; i++) begin
         next_slot[i] = i + 1;
         held_key[i]  = '0;
         held_val[i]  = '0;
      end
      free_first = 0;
      entries    = 0;
   endtask

   task automatic apply_request(input logic [1:0] op, input logic [63:0] key,
                                input logic [63:0] value, output lookup_result_type res);
      logic [31:0] folded;
      int          bin;
      int          cur;
      int          prev;
      int          found;
      int          steps;
      int          fresh;
      folded = key[31:0] ^ key[63:32];
      bin    = folded % chm_pkg::BIN_COUNT;
      res    = '{1'b0, 64'd0, 1'b0, 9'd0};
      found  = chm_pkg::ENTRY_SLOTS;
      prev   = chm_pkg::ENTRY_SLOTS;
      if (op != chm_pkg::REQ_BAD) begin
         cur   = bin_first[bin];
         steps = 0;
         while (cur < chm_pkg::ENTRY_SLOTS && steps < chm_pkg::ENTRY_SLOTS
                && found == chm_pkg::ENTRY_SLOTS) begin
            if (held_key[cur] == key) found = cur;
            else begin
               prev = cur;
               cur  = next_slot[cur];
               steps++;
            end
         end
      end
      case (op)
         chm_pkg::REQ_SET: begin
            if (found < chm_pkg::ENTRY_SLOTS) begin
               res.hit         = 1'b1;
               held_val[found] = value;
            end else if (free_first < chm_pkg::ENTRY_SLOTS) begin
               fresh            = free_first;
               free_first       = next_slot[fresh];
               held_key[fresh]  = key;
               held_val[fresh]  = value;
               next_slot[fresh] = bin_first[bin];
               bin_first[bin]   = fresh;
               entries++;
            end else begin
               res.table_full = 1'b1;
            end
         end
         chm_pkg::REQ_GET: begin
            if (found < chm_pkg::ENTRY_SLOTS) begin
               res.hit        = 1'b1;
               res.read_value = held_val[found];
            end
         end
         chm_pkg::REQ_DEL: begin
            if (found < chm_pkg::ENTRY_SLOTS) begin
               res.hit = 1'b1;
               if (prev < chm_pkg::ENTRY_SLOTS) next_slot[prev] = next_slot[found];
               else bin_first[bin] = next_slot[found];
               next_slot[found] = free_first;
               free_first       = found;
               held_key[found]  = '0;
               held_val[found]  = '0;
               if (entries > 0) entries--;
            end
         end
         default: ;
      endcase
      res.stored_count = entries[8:0];
   endtask

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      failures++;
   endtask

   initial begin
      failures = 0;
      clear_table();
   end

   always @(posedge clock) begin
      lookup_result_type res;
      lookup_result_type want;
      if (reset) begin
         clear_table();
         result_queue.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            apply_request(req_tuser, req_tdata[63:0], req_tdata[127:64], res);
            result_queue.push_back(res);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (result_queue.size() == 0) begin
               report("unexpected response", rsp_tdata[63:0], 64'd0);
            end else begin
               want = result_queue.pop_front();
               if (rsp_tdata[0] !== want.hit)
                  report("hit", 64'(rsp_tdata[0]), 64'(want.hit));
               if (rsp_tdata[64:1] !== want.read_value)
                  report("read_value", rsp_tdata[64:1], want.read_value);
               if (rsp_tdata[65] !== want.table_full)
                  report("table_full", 64'(rsp_tdata[65]), 64'(want.table_full));
               if (rsp_tdata[74:66] !== want.stored_count)
                  report("stored_count", 64'(rsp_tdata[74:66]), 64'(want.stored_count));
            end
         end
      end
   end
endmodule

[tb/chained_hash_map_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// chained_hash_map_tb
// Drives set, get and delete transactions into the hash map with bursty
// traffic and a stalling receiver; a checker module predicts every response.
// ----------------------------------------------------------------------------
module chained_hash_map_tb;
   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [1:0]   req_tuser = chm_pkg::REQ_GET;
   logic [127:0] req_tdata = '0;  // key [63:0], value [127:64]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [79:0]  rsp_tdata;       // hit, read_value, table_full, stored_count
   int           failures;
   int           pending;

   // Pool of keys that recur so that gets, updates and deletes find entries.
   logic [63:0]  key_pool[$];

   always #5 clock = ~clock;

   chained_hash_map dut (.*);

   chained_hash_map_checker checker_inst (.*);

   // Builds a random key; half of them are steered into four neighboring bins
   // so that chains grow long enough to exercise middle and tail unlinking.
   function automatic logic [63:0] random_key();
      logic [63:0] k;
      k = {$urandom, $urandom};
      if ($urandom_range(1)) k[8:0] = k[40:32] ^ 9'($urandom_range(3));
      return k;
   endfunction

   // One transaction: raise valid and hold it until the block takes it.
   task automatic send(input logic [1:0] op, input logic [63:0] key, input logic [63:0] value);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {value, key};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic idle(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Sends a random request, bursty: after each transaction a gap may follow.
   task automatic send_mixed(input int set_pct, input int del_pct);
      int          roll;
      logic [1:0]  op;
      logic [63:0] key;
      roll = $urandom_range(99);
      if (roll < set_pct) op = chm_pkg::REQ_SET;
      else if (roll < set_pct + del_pct) op = chm_pkg::REQ_DEL;
      else if (roll < 96) op = chm_pkg::REQ_GET;
      else op = chm_pkg::REQ_BAD;
      if (key_pool.size() > 0 && $urandom_range(9) < 8) begin
         key = key_pool[$urandom_range(key_pool.size() - 1)];
      end else begin
         key = random_key();
         key_pool.push_back(key);
      end
      send(op, key, {$urandom, $urandom});
      if ($urandom_range(7) == 0) idle($urandom_range(1, 12));
   endtask

   // Sender pause until every outstanding response has come back.
   task automatic drain();
      idle(1);
      while (pending != 0) @(posedge clock);
   endtask

   // Receiver: stall behavior rotates between no stalls, light and heavy
   // stalling. Two long hold-offs let the block back up.
   always @(posedge clock) begin
      int unsigned cycle;
      int unsigned mode;
      cycle++;
      mode = (cycle / 256) % 3;
      if ((cycle >= 3000 && cycle < 3400) || (cycle >= 9000 && cycle < 9300))
         rsp_tready <= 1'b0;
      else if (mode == 0) rsp_tready <= 1'b1;
      else if (mode == 1) rsp_tready <= ($urandom_range(3) != 0);
      else rsp_tready <= ($urandom_range(3) == 0);
   end

   initial begin
      #50ms;
      $display("FAILURE");
      $finish;
   end

   initial begin
      logic [63:0] chain_a;
      logic [63:0] chain_b;
      logic [63:0] chain_c;
      chain_a = 64'h0000_0000_0000_0007;
      chain_b = 64'h0000_0000_0000_0207;
      chain_c = 64'h0000_0000_0000_0407;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes of key and value, updates, misses and a chain of
      // three keys in one bin unlinked from the middle, the tail and the head.
      send(chm_pkg::REQ_GET, 64'd0, 64'd0);
      send(chm_pkg::REQ_SET, 64'd0, '1);
      send(chm_pkg::REQ_GET, 64'd0, 64'd0);
      send(chm_pkg::REQ_SET, '1, 64'd0);
      send(chm_pkg::REQ_GET, '1, '1);
      send(chm_pkg::REQ_SET, 64'd0, 64'd5);
      send(chm_pkg::REQ_GET, 64'd0, 64'd0);
      send(chm_pkg::REQ_DEL, 64'd123, 64'd0);
      send(chm_pkg::REQ_DEL, 64'd0, 64'd0);
      send(chm_pkg::REQ_GET, 64'd0, 64'd0);
      send(chm_pkg::REQ_BAD, '1, '1);
      send(chm_pkg::REQ_SET, chain_a, 64'hA);
      send(chm_pkg::REQ_SET, chain_b, 64'hB);
      send(chm_pkg::REQ_SET, chain_c, 64'hC);
      send(chm_pkg::REQ_DEL, chain_b, 64'd0);
      send(chm_pkg::REQ_GET, chain_a, 64'd0);
      send(chm_pkg::REQ_GET, chain_c, 64'd0);
      send(chm_pkg::REQ_GET, chain_b, 64'd0);
      send(chm_pkg::REQ_DEL, chain_a, 64'd0);
      send(chm_pkg::REQ_DEL, chain_c, 64'd0);
      send(chm_pkg::REQ_DEL, '1, 64'd0);
      send(chm_pkg::REQ_SET, 64'h5555_5555_AAAA_AAAA, 64'hAAAA_5555_0F0F_F0F0);
      drain();

      // Mixed traffic over a small key set, hitting the first long hold-off.
      for (int i = 0; i < 48; i++) key_pool.push_back(random_key());
      for (int i = 0; i < 650; i++) send_mixed(40, 25);
      drain();

      // Fill the table past capacity so sets of new keys get dropped.
      for (int i = 0; i < 280; i++) begin
         logic [63:0] k;
         k = random_key();
         key_pool.push_back(k);
         send(chm_pkg::REQ_SET, k, {$urandom, $urandom});
         if ($urandom_range(15) == 0) idle($urandom_range(1, 8));
      end

      // Churn near and at the full mark with deletes freeing slots.
      for (int i = 0; i < 850; i++) send_mixed(35, 35);

      drain();
      repeat (600) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
